### src/mhcc_pkg.sv
package mhcc_pkg;

  localparam int TABLE_BITS = 12;
  localparam int WORD_BITS  = 64;
  localparam int HALF_BITS  = WORD_BITS / 2;
  localparam int SHIFT_W    = $clog2(WORD_BITS + 1);
  localparam int EPOCH_BITS = 8;
  localparam int IB_W       = 4;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 64;

  localparam logic [IB_W-1:0] IB_RESET = IB_W'(12);

  localparam logic [CFG_IDX_W-1:0] REG_MAGIC      = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_INDEX_BITS = CFG_IDX_W'(1);

  typedef struct packed {
    logic accept;
    logic clr;
    logic mul0;
    logic mul1;
    logic mul2;
    logic rd;
    logic chk;
    logic emit;
  } mhcc_cmd_t;

  typedef struct packed {
    logic wrap;
    logic clr_last;
    logic last;
    logic out_full;
  } mhcc_sts_t;

endpackage

### src/mhcc_in_if.sv
interface mhcc_in_if;
  logic                            valid;
  logic                            ready;
  logic [mhcc_pkg::WORD_BITS-1:0]  key;
  logic [mhcc_pkg::WORD_BITS-1:0]  value;
  logic                            first;
  logic                            last;

  modport source (output valid, key, value, first, last, input ready);
  modport sink   (input valid, key, value, first, last, output ready);
endinterface

### src/mhcc_out_if.sv
interface mhcc_out_if;
  logic valid;
  logic ready;
  logic is_valid;

  modport source (output valid, is_valid, input ready);
  modport sink   (input valid, is_valid, output ready);
endinterface

### src/magic_hash_collision_checker_core.sv
// after acceptance a word passes the shared 32x32 multiplier (3 passes), the table
// read and the check before in_ready returns; a last word then also passes the emit
// step, which registers the result word and stalls while the old result is not taken
// reset (rst_n low, synchronous) clears run state, then a sweep over all 2^TABLE_BITS
// slots clears the table with in_ready low; the sweep recurs on every 255th first word
module magic_hash_collision_checker_core #(
  parameter int TABLE_BITS = mhcc_pkg::TABLE_BITS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  mhcc_in_if.sink                         in_chan,
  mhcc_out_if.source                      out_chan,
  input  logic                            cfg_we,
  input  logic [mhcc_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [mhcc_pkg::CFG_DATA_W-1:0] cfg_data
);

  mhcc_pkg::mhcc_cmd_t cmd;
  mhcc_pkg::mhcc_sts_t sts;

  mhcc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  mhcc_dp #(
    .TABLE_BITS (TABLE_BITS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_idx      (cfg_idx),
    .cfg_data     (cfg_data),
    .in_key       (in_chan.key),
    .in_value     (in_chan.value),
    .in_first     (in_chan.first),
    .in_last      (in_chan.last),
    .out_ready    (out_chan.ready),
    .out_valid    (out_chan.valid),
    .out_is_valid (out_chan.is_valid),
    .cmd          (cmd),
    .sts          (sts)
  );

endmodule

### src/mhcc_ram.sv
module mhcc_ram #(
  parameter int WIDTH = 72,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### src/mhcc_ctrl.sv
module mhcc_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  mhcc_pkg::mhcc_sts_t   sts,
  output mhcc_pkg::mhcc_cmd_t   cmd
);

  typedef enum logic [7:0] {
    ST_CLR  = 8'b0000_0001,
    ST_IDLE = 8'b0000_0010,
    ST_MUL0 = 8'b0000_0100,
    ST_MUL1 = 8'b0000_1000,
    ST_MUL2 = 8'b0001_0000,
    ST_RD   = 8'b0010_0000,
    ST_CHK  = 8'b0100_0000,
    ST_EMIT = 8'b1000_0000
  } mhcc_state_t;

  mhcc_state_t state_r, state_nxt;
  logic        pend_r, pend_nxt;

  always_comb begin
    state_nxt = state_r;
    pend_nxt  = pend_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_CLR: begin
        cmd.clr = 1'b1;
        if (sts.clr_last) begin
          state_nxt = pend_r ? ST_MUL0 : ST_IDLE;
          pend_nxt  = 1'b0;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (sts.wrap) begin
            state_nxt = ST_CLR;
            pend_nxt  = 1'b1;
          end else begin
            state_nxt = ST_MUL0;
          end
        end
      end
      ST_MUL0: begin
        cmd.mul0  = 1'b1;
        state_nxt = ST_MUL1;
      end
      ST_MUL1: begin
        cmd.mul1  = 1'b1;
        state_nxt = ST_MUL2;
      end
      ST_MUL2: begin
        cmd.mul2  = 1'b1;
        state_nxt = ST_RD;
      end
      ST_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = ST_CHK;
      end
      ST_CHK: begin
        cmd.chk   = 1'b1;
        state_nxt = sts.last ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        if (!sts.out_full) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLR;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= pend_nxt;
    end
  end

  // a pending item only waits behind a clearing sweep
  assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> state_r == ST_CLR)
    else $error("pending item outside clearing sweep");

  // a word is only taken while idle
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept |=> (state_r == ST_MUL0 || state_r == ST_CLR))
    else $error("accepted word did not start hashing");

  assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r))
    else $error("controller state not one-hot");

endmodule

### src/mhcc_dp.sv
module mhcc_dp #(
  parameter int TABLE_BITS = mhcc_pkg::TABLE_BITS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [mhcc_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  logic [mhcc_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic [mhcc_pkg::WORD_BITS-1:0]      in_key,
  input  logic [mhcc_pkg::WORD_BITS-1:0]      in_value,
  input  logic                                in_first,
  input  logic                                in_last,
  input  logic                                out_ready,
  output logic                                out_valid,
  output logic                                out_is_valid,
  input  mhcc_pkg::mhcc_cmd_t                 cmd,
  output mhcc_pkg::mhcc_sts_t                 sts
);

  localparam int WB    = mhcc_pkg::WORD_BITS;
  localparam int HB    = mhcc_pkg::HALF_BITS;
  localparam int EB    = mhcc_pkg::EPOCH_BITS;
  localparam int SW    = mhcc_pkg::SHIFT_W;
  localparam int DEPTH = 1 << TABLE_BITS;
  localparam int ENT_W = EB + WB;

  logic [WB-1:0]                magic_r;
  logic [mhcc_pkg::IB_W-1:0]    ib_r;
  logic [WB-1:0]                key_r;
  logic [WB-1:0]                value_r;
  logic                         last_r;
  logic [WB-1:0]                acc_r, acc_nxt;
  logic [TABLE_BITS-1:0]        slot_r, slot_nxt;
  logic [TABLE_BITS-1:0]        clr_cnt_r;
  logic [EB-1:0]                epoch_r;
  logic                         failed_r;
  logic                         out_valid_r;
  logic                         out_is_valid_r;

  logic [HB-1:0]     mul_a, mul_b;
  logic [WB-1:0]     mul_p;
  logic [SW-1:0]     ib_ext, tb_ext, bits_eff, shamt;
  logic [WB-1:0]     hashed;
  logic              ram_we;
  logic [TABLE_BITS-1:0] ram_waddr;
  logic [ENT_W-1:0]  ram_wdata, ram_rdata;
  logic [EB-1:0]     ent_tag;
  logic [WB-1:0]     ent_val;
  logic              seen;

  // low 64 bits of key * magic from three 32x32 partial products
  assign mul_a = (cmd.mul1) ? key_r[WB-1:HB] : key_r[HB-1:0];
  assign mul_b = (cmd.mul2) ? magic_r[WB-1:HB] : magic_r[HB-1:0];
  assign mul_p = WB'(mul_a) * WB'(mul_b);

  always_comb begin
    acc_nxt = acc_r;
    if (cmd.mul0) begin
      acc_nxt = mul_p;
    end else if (cmd.mul1 || cmd.mul2) begin
      acc_nxt = {acc_r[WB-1:HB] + mul_p[HB-1:0], acc_r[HB-1:0]};
    end
  end

  // index width saturates at the table size; zero bits gives slot zero
  assign ib_ext   = SW'(ib_r);
  assign tb_ext   = SW'(TABLE_BITS);
  assign bits_eff = (ib_ext > tb_ext) ? tb_ext : ib_ext;
  assign shamt    = SW'(WB) - bits_eff;
  assign hashed   = acc_r >> shamt;
  assign slot_nxt = cmd.rd ? hashed[TABLE_BITS-1:0] : slot_r;

  assign ent_tag = ram_rdata[ENT_W-1:WB];
  assign ent_val = ram_rdata[WB-1:0];
  assign seen    = (ent_tag == epoch_r);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = slot_r;
    ram_wdata = {epoch_r, value_r};
    if (cmd.clr) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt_r;
      ram_wdata = '0;
    end else if (cmd.chk && !failed_r && !seen) begin
      ram_we    = 1'b1;
    end
  end

  mhcc_ram #(
    .WIDTH (ENT_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.rd),
    .raddr (slot_nxt),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    acc_r  <= acc_nxt;
    slot_r <= slot_nxt;
    if (cmd.accept) begin
      key_r   <= in_key;
      value_r <= in_value;
      last_r  <= in_last;
    end
    if (cmd.emit) begin
      out_is_valid_r <= !failed_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      magic_r     <= '0;
      ib_r        <= mhcc_pkg::IB_RESET;
      clr_cnt_r   <= '0;
      epoch_r     <= EB'(1);
      failed_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          mhcc_pkg::REG_MAGIC:      magic_r <= cfg_data;
          mhcc_pkg::REG_INDEX_BITS: ib_r    <= cfg_data[mhcc_pkg::IB_W-1:0];
          default: ;
        endcase
      end
      if (cmd.clr) begin
        clr_cnt_r <= clr_cnt_r + TABLE_BITS'(1);
      end
      // new run: fresh epoch, all slots read as empty
      if (cmd.accept && in_first) begin
        epoch_r  <= (epoch_r == '1) ? EB'(1) : epoch_r + EB'(1);
        failed_r <= 1'b0;
      end else if (cmd.chk && !failed_r && seen && ent_val != value_r) begin
        failed_r <= 1'b1;
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign sts.wrap     = in_first && (epoch_r == '1);
  assign sts.clr_last = (clr_cnt_r == '1);
  assign sts.last     = last_r;
  assign sts.out_full = out_valid_r && !out_ready;

  assign out_valid    = out_valid_r;
  assign out_is_valid = out_is_valid_r;

  // epoch zero marks cleared slots and is never current
  assert property (@(posedge clk) disable iff (!rst_n)
    epoch_r != '0)
    else $error("epoch reached cleared-slot mark");

  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(failed_r) |-> $past(cmd.chk))
    else $error("failure flag set outside check step");

  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(cmd.emit))
    else $error("result word appeared without emit");

endmodule

### tb/tb.sv
`timescale 1ns / 100ps

module tb;

  localparam int TABLE_BITS = mhcc_pkg::TABLE_BITS;
  localparam int SLOTS = 1 << TABLE_BITS;
  localparam logic [63:0] ALL_ONES = {64{1'b1}};

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [mhcc_pkg::CFG_IDX_W-1:0] cfg_idx;
  logic [mhcc_pkg::CFG_DATA_W-1:0] cfg_data;

  mhcc_in_if in_chan ();
  mhcc_out_if out_chan ();

  magic_hash_collision_checker_core u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  // hash table shadow
  logic [63:0] magic_reg;
  logic [3:0] ibits_reg;
  bit [SLOTS-1:0] seen_slot;
  logic [63:0] stored_val [SLOTS];
  bit run_failed;
  bit verdicts_due [$];

  bit calm;
  int mismatches;
  int pairs_sent;
  int pairs_hashed;
  int runs_reported;
  int passes_seen;
  int fails_seen;
  int settings_used;
  bit want_valid;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("tb failed");
    $finish;
  end

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [TABLE_BITS-1:0] slot_of(input logic [63:0] k);
    int b;
    logic [63:0] prod;
    b = (ibits_reg > TABLE_BITS) ? TABLE_BITS : int'(ibits_reg);
    if (b == 0) return '0;
    prod = k * magic_reg;
    return TABLE_BITS'(prod >> (64 - b));
  endfunction

  // returns 1 when the pair is hashed, 0 when a failed run ignores it
  function automatic bit track_pair(input logic [63:0] k, input logic [63:0] v,
                                    input logic f, input logic l);
    logic [TABLE_BITS-1:0] s;
    bit hashed;
    if (f) begin
      seen_slot = '0;
      run_failed = 1'b0;
    end
    hashed = !run_failed;
    if (!run_failed) begin
      s = slot_of(k);
      if (!seen_slot[s]) begin
        seen_slot[s] = 1'b1;
        stored_val[s] = v;
      end else if (stored_val[s] != v) begin
        run_failed = 1'b1;
      end
    end
    if (l) begin
      verdicts_due.insert(verdicts_due.size(), !run_failed);
      runs_reported++;
    end
    return hashed;
  endfunction

  task automatic send_pair(input logic [63:0] k, input logic [63:0] v,
                           input logic f, input logic l);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.key <= k;
    in_chan.value <= v;
    in_chan.first <= f;
    in_chan.last <= l;
    @(posedge clk);
    while (in_chan.ready !== 1'b1) @(posedge clk);
    pairs_sent++;
    if (track_pair(k, v, f, l)) pairs_hashed++;
  endtask

  task automatic settle();
    in_chan.valid <= 1'b0;
    while (verdicts_due.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    while (in_chan.ready !== 1'b1) @(posedge clk);
  endtask

  task automatic set_config(input logic [63:0] magic, input logic [3:0] ib);
    cfg_we <= 1'b1;
    cfg_idx <= mhcc_pkg::REG_MAGIC;
    cfg_data <= magic;
    @(posedge clk);
    magic_reg = magic;
    cfg_idx <= mhcc_pkg::REG_INDEX_BITS;
    cfg_data <= {60'(rand64()), ib};
    @(posedge clk);
    ibits_reg = ib;
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // defaults after reset: zero multiplier puts every key in slot 0
  task automatic test_power_on_run();
    send_pair(ALL_ONES, 64'd0, 1'b0, 1'b0);
    send_pair(64'd0, 64'd0, 1'b0, 1'b1);
    send_pair(64'h5555_5555_5555_5555, ALL_ONES, 1'b0, 1'b1);
    send_pair(rand64(), 64'd0, 1'b0, 1'b1);
    send_pair(64'd0, ALL_ONES, 1'b1, 1'b1);
    settle();
  endtask

  task automatic test_index_zero();
    set_config(ALL_ONES, 4'd0);
    send_pair(64'h0123_4567_89ab_cdef, 64'hAAAA_AAAA_AAAA_AAAA, 1'b1, 1'b0);
    send_pair(64'hfedc_ba98_7654_3210, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 1'b0);
    send_pair(ALL_ONES, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 1'b1);
    send_pair(64'h0123_4567_89ab_cdef, 64'h1, 1'b1, 1'b0);
    send_pair(64'hfedc_ba98_7654_3210, 64'h2, 1'b0, 1'b0);
    send_pair(64'd0, 64'h1, 1'b0, 1'b1);
    settle();
  endtask

  task automatic test_index_saturation();
    set_config(64'h9E37_79B9_7F4A_7C15, 4'd15);
    send_pair(rand64(), rand64(), 1'b1, 1'b1);
    send_pair(64'd0, 64'd7, 1'b1, 1'b0);
    send_pair(ALL_ONES, 64'd7, 1'b0, 1'b0);
    send_pair(64'd1, 64'd9, 1'b0, 1'b0);
    send_pair(64'd0, 64'd7, 1'b0, 1'b1);
    settle();
  endtask

  task automatic test_index_one();
    set_config(64'h8000_0000_0000_0001, 4'd1);
    send_pair(64'd1, 64'd3, 1'b1, 1'b0);
    send_pair(64'd2, 64'd4, 1'b0, 1'b0);
    send_pair(64'd3, 64'd5, 1'b0, 1'b1);
    send_pair(64'd2, 64'd4, 1'b1, 1'b1);
    settle();
  endtask

  task automatic test_random_runs();
    logic [63:0] run_keys [16];
    logic [63:0] vals [4];
    logic [63:0] k;
    logic [3:0] ib;
    logic [63:0] magic;
    logic f;
    logic l;
    int phase_left;
    int len;
    int nv;
    int kind;
    phase_left = 0;
    while (pairs_sent < 1250) begin
      if (phase_left <= 0) begin
        settle();
        case ($urandom_range(0, 5))
          0: ib = 4'd0;
          1: ib = 4'($urandom_range(13, 15));
          2: ib = 4'd12;
          default: ib = 4'($urandom_range(1, 8));
        endcase
        case ($urandom_range(0, 9))
          0: magic = 64'd0;
          1: magic = ALL_ONES;
          2: magic = 64'd1;
          3: magic = 64'h8000_0000_0000_0000;
          default: magic = rand64();
        endcase
        set_config(magic, ib);
        calm = ($urandom_range(0, 4) == 0);
        phase_left = $urandom_range(40, 120);
      end
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 16) : $urandom_range(1, 6);
      nv = $urandom_range(1, 3);
      foreach (vals[j]) begin
        case ($urandom_range(0, 5))
          0: vals[j] = 64'd0;
          1: vals[j] = ALL_ONES;
          default: vals[j] = rand64();
        endcase
      end
      // mostly well formed runs, the rest broken or stray words
      kind = $urandom_range(0, 9);
      for (int i = 0; i < len; i++) begin
        f = (i == 0) && (kind != 0);
        l = (i == len - 1) && (kind != 1);
        if (kind == 2 && i == len / 2) f = 1'b1;
        if (kind == 3) begin
          f = 1'($urandom_range(0, 1));
          l = 1'($urandom_range(0, 1));
        end
        if (i > 0 && $urandom_range(0, 9) < 3)
          k = run_keys[$urandom_range(0, i - 1)];
        else
          k = rand64();
        run_keys[i] = k;
        send_pair(k, vals[$urandom_range(0, nv - 1)], f, l);
      end
      phase_left -= len;
    end
    settle();
  endtask

  initial begin
    out_chan.ready <= 1'b0;
    @(posedge clk);
    forever begin
      int stall;
      stall = pick_gap();
      if (stall > 0) begin
        out_chan.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_chan.ready <= 1'b1;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_chan.valid === 1'b1 && out_chan.ready === 1'b1) begin
      if (verdicts_due.size() == 0) begin
        $display("%0t: unexpected result word, expected none actual %b",
                 $time, out_chan.is_valid);
        mismatches++;
      end else begin
        want_valid = verdicts_due.pop_front();
        if (out_chan.is_valid !== want_valid) begin
          $display("%0t: is_valid mismatch, expected %b actual %b",
                   $time, want_valid, out_chan.is_valid);
          mismatches++;
        end
        if (want_valid) passes_seen++;
        else fails_seen++;
      end
    end
  end

  initial begin
    rst_n <= 1'b0;
    in_chan.valid <= 1'b0;
    in_chan.key <= '0;
    in_chan.value <= '0;
    in_chan.first <= 1'b0;
    in_chan.last <= 1'b0;
    cfg_we <= 1'b0;
    cfg_idx <= '0;
    cfg_data <= '0;
    magic_reg = '0;
    ibits_reg = mhcc_pkg::IB_RESET;
    seen_slot = '0;
    run_failed = 1'b0;
    calm = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    test_power_on_run();
    test_index_zero();
    test_index_saturation();
    test_index_one();
    test_random_runs();

    repeat (20) @(posedge clk);
    $display("sent %0d pairs, %0d hashed, under %0d register settings",
             pairs_sent, pairs_hashed, settings_used);
    $display("checked %0d run verdicts: %0d valid, %0d with a conflicting collision",
             runs_reported, passes_seen, fails_seen);
    if (mismatches == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

### filelist.f
src/mhcc_pkg.sv
src/mhcc_in_if.sv
src/mhcc_out_if.sv
src/mhcc_ram.sv
src/mhcc_ctrl.sv
src/mhcc_dp.sv
src/magic_hash_collision_checker_core.sv
tb/tb.sv
